>>> sv/hwm_pkg.sv
// Shared types and constants for the holonomic wheel mixer.
// No dependencies; every other file imports this package.
package hwm_pkg;

    localparam int IN_W      = 16;
    localparam int GAIN_W    = 24;
    localparam int LIM_W     = 15;
    localparam int OUT_W     = 16;
    localparam int QUO_W     = LIM_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = GAIN_W;
    localparam int LATENCY   = QUO_W + 3;

    localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST = 24'd55117;
    localparam logic [GAIN_W-1:0] TURN_GAIN_RST   = 24'd171443;
    localparam logic [LIM_W-1:0]  MAX_SPEED_RST   = 15'd8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINEAR_GAIN = 2'd0,
        REG_TURN_GAIN   = 2'd1,
        REG_MAX_SPEED   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic       valid;
        logic       limited;
        logic [2:0] neg;
    } hwm_ctl_t;

endpackage

>>> sv/hwm_scale.sv
// Front end: gain multiply, magnitude sum, limit test, numerator and denominator build.
// Depends on hwm_pkg.
module hwm_scale #(
    parameter int FRAC_BITS = 8,
    parameter int CW        = 40 - 2 * FRAC_BITS,
    parameter int SUM_W     = CW + 2,
    parameter int NUM_W     = CW + 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [hwm_pkg::IN_W-1:0] forward_speed,
    input  logic signed [hwm_pkg::IN_W-1:0] lateral_speed,
    input  logic signed [hwm_pkg::IN_W-1:0] turn_rate,
    input  logic [hwm_pkg::GAIN_W-1:0]     linear_gain,
    input  logic [hwm_pkg::GAIN_W-1:0]     turn_gain,
    input  logic [hwm_pkg::LIM_W-1:0]      max_speed,
    output hwm_pkg::hwm_ctl_t              ctl,
    output logic [NUM_W-1:0]               num [3],
    output logic [SUM_W-1:0]               den
);
    import hwm_pkg::*;

    localparam int PROD_W = IN_W + GAIN_W;

    logic signed [IN_W-1:0] spd [3];
    logic [GAIN_W-1:0]      gain [3];
    logic [IN_W-1:0]        mag [3];
    logic [PROD_W-1:0]      prod [3];
    logic [CW-1:0]          comp_next [3];
    logic [CW-1:0]          comp_reg [3];
    logic [2:0]             neg_next;
    logic [2:0]             neg_reg;
    logic                   s1_valid_reg;
    logic [SUM_W-1:0]       sum;
    logic                   limited;
    logic [NUM_W-1:0]       num_next [3];
    logic [NUM_W-1:0]       num_reg [3];
    logic [SUM_W-1:0]       den_next;
    logic [SUM_W-1:0]       den_reg;
    hwm_ctl_t               ctl_next;
    hwm_ctl_t               ctl_reg;

    always_comb
    begin
        spd[0]  = forward_speed;
        spd[1]  = lateral_speed;
        spd[2]  = turn_rate;
        gain[0] = linear_gain;
        gain[1] = linear_gain;
        gain[2] = turn_gain;
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i]  = spd[i][IN_W-1];
            mag[i]       = spd[i][IN_W-1] ? IN_W'(-spd[i]) : IN_W'(spd[i]);
            prod[i]      = PROD_W'(mag[i]) * PROD_W'(gain[i]);
            comp_next[i] = prod[i][PROD_W-1:2*FRAC_BITS];
        end
    end

    always_comb
    begin
        sum     = SUM_W'(comp_reg[0]) + SUM_W'(comp_reg[1]) + SUM_W'(comp_reg[2]);
        limited = sum > SUM_W'(max_speed);
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = limited ? NUM_W'(comp_reg[i]) * NUM_W'(max_speed)
                                  : NUM_W'(comp_reg[i]);
        end
        den_next         = limited ? sum : SUM_W'(1);
        ctl_next.valid   = s1_valid_reg;
        ctl_next.limited = limited;
        ctl_next.neg     = neg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            ctl_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            ctl_reg      <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        comp_reg <= comp_next;
        neg_reg  <= neg_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
    end

    assign ctl = ctl_reg;
    assign num = num_reg;
    assign den = den_reg;

endmodule

>>> sv/hwm_div.sv
// Three-lane restoring divider, one quotient bit per pipeline stage.
// Depends on hwm_pkg.
module hwm_div #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 26
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hwm_pkg::hwm_ctl_t            ctl_in,
    input  logic [NUM_W-1:0]             num [3],
    input  logic [DEN_W-1:0]             den,
    output hwm_pkg::hwm_ctl_t            ctl_out,
    output logic [hwm_pkg::QUO_W-1:0]    quo [3]
);
    import hwm_pkg::*;

    localparam int CMP_W = NUM_W + 2;

    hwm_ctl_t         ctl_reg [QUO_W];
    logic [NUM_W-1:0] rem_reg [QUO_W][3];
    logic [QUO_W-1:0] quo_reg [QUO_W][3];
    logic [DEN_W-1:0] den_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        localparam int K = QUO_W - 1 - s;

        hwm_ctl_t         ctl_cur;
        logic [NUM_W-1:0] rem_cur [3];
        logic [QUO_W-1:0] quo_cur [3];
        logic [DEN_W-1:0] den_cur;
        logic [CMP_W-1:0] trial;
        logic [NUM_W-1:0] rem_next [3];
        logic [QUO_W-1:0] quo_next [3];

        if (s == 0)
        begin : g_first
            assign ctl_cur = ctl_in;
            assign rem_cur = num;
            assign den_cur = den;
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    quo_cur[i] = '0;
                end
            end
        end
        else
        begin : g_rest
            assign ctl_cur = ctl_reg[s-1];
            assign rem_cur = rem_reg[s-1];
            assign quo_cur = quo_reg[s-1];
            assign den_cur = den_reg[s-1];
        end

        always_comb
        begin
            trial = CMP_W'(den_cur) << K;
            for (int i = 0; i < 3; i++)
            begin
                quo_next[i] = quo_cur[i];
                if (CMP_W'(rem_cur[i]) >= trial)
                begin
                    rem_next[i]    = NUM_W'(CMP_W'(rem_cur[i]) - trial);
                    quo_next[i][K] = 1'b1;
                end
                else
                begin
                    rem_next[i] = rem_cur[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s] <= '0;
            end
            else
            begin
                ctl_reg[s] <= ctl_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            quo_reg[s] <= quo_next;
            den_reg[s] <= den_cur;
        end
    end

    assign ctl_out = ctl_reg[QUO_W-1];
    assign quo     = quo_reg[QUO_W-1];

endmodule

>>> sv/hwm_mix.sv
// Back end: restore signs, mix per wheel, negate and register the beat.
// Depends on hwm_pkg.
module hwm_mix (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hwm_pkg::hwm_ctl_t                ctl_in,
    input  logic [hwm_pkg::QUO_W-1:0]        quo [3],
    output logic                             done,
    output logic signed [hwm_pkg::OUT_W-1:0] rear_left_target,
    output logic signed [hwm_pkg::OUT_W-1:0] rear_right_target,
    output logic signed [hwm_pkg::OUT_W-1:0] front_left_target,
    output logic signed [hwm_pkg::OUT_W-1:0] front_right_target,
    output logic                             speed_limited
);
    import hwm_pkg::*;

    localparam int MW = OUT_W + 1;

    logic signed [MW-1:0]    comp [3];
    logic signed [MW-1:0]    rl_mix;
    logic signed [MW-1:0]    rr_mix;
    logic signed [MW-1:0]    fl_mix;
    logic signed [MW-1:0]    fr_mix;
    logic                    done_reg;
    logic signed [OUT_W-1:0] rl_reg;
    logic signed [OUT_W-1:0] rr_reg;
    logic signed [OUT_W-1:0] fl_reg;
    logic signed [OUT_W-1:0] fr_reg;
    logic                    limited_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            comp[i] = ctl_in.neg[i] ? -$signed(MW'(quo[i])) : $signed(MW'(quo[i]));
        end
        rl_mix = -(comp[0] + comp[1] - comp[2]);
        rr_mix = -(-comp[0] + comp[1] - comp[2]);
        fl_mix = -(comp[0] - comp[1] - comp[2]);
        fr_mix = -(-comp[0] - comp[1] - comp[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rl_reg      <= rl_mix[OUT_W-1:0];
        rr_reg      <= rr_mix[OUT_W-1:0];
        fl_reg      <= fl_mix[OUT_W-1:0];
        fr_reg      <= fr_mix[OUT_W-1:0];
        limited_reg <= ctl_in.limited;
    end

    assign done               = done_reg;
    assign rear_left_target   = rl_reg;
    assign rear_right_target  = rr_reg;
    assign front_left_target  = fl_reg;
    assign front_right_target = fr_reg;
    assign speed_limited      = limited_reg;

endmodule

>>> sv/holonomic_wheel_mixer.sv
// Holonomic wheel mixer: body velocity command to four omni wheel targets.
// Depends on hwm_pkg, hwm_scale, hwm_div and hwm_mix.
//
// Usage:
//   Command beat: drive forward_speed, lateral_speed and turn_rate and raise
//   start; the beat is taken on any edge with start high and busy low.
//   busy stays low, so a new command may enter on every cycle.
//   Result beat: done is high for one cycle with the four wheel targets and
//   speed_limited; the receiver must take it in that cycle.
//   Pipeline: 2 front-end stages, 15 divider stages and 1 mix stage lie
//   between the accepting edge and the edge that ends the done cycle.
//   Throughput: one command per cycle, set by the one-bit-per-stage divider.
//   Config: cfg_wr with cfg_index and cfg_data writes linear_gain (0),
//   turn_gain (1) or max_speed (2) on that edge; other indexes are dropped.
//   Write only while no command is in flight.
//   Reset: the pipeline empties, done drops, and the three registers return
//   to their default gains and limit.
module holonomic_wheel_mixer #(
    parameter int FRAC_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [hwm_pkg::IN_W-1:0]  forward_speed,
    input  logic signed [hwm_pkg::IN_W-1:0]  lateral_speed,
    input  logic signed [hwm_pkg::IN_W-1:0]  turn_rate,
    output logic                             done,
    output logic signed [hwm_pkg::OUT_W-1:0] rear_left_target,
    output logic signed [hwm_pkg::OUT_W-1:0] rear_right_target,
    output logic signed [hwm_pkg::OUT_W-1:0] front_left_target,
    output logic signed [hwm_pkg::OUT_W-1:0] front_right_target,
    output logic                             speed_limited,
    input  logic                             cfg_wr,
    input  logic [hwm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hwm_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import hwm_pkg::*;

    localparam int CW    = IN_W + GAIN_W - 2 * FRAC_BITS;
    localparam int SUM_W = CW + 2;
    localparam int NUM_W = CW + LIM_W;

    logic [GAIN_W-1:0] linear_gain_reg;
    logic [GAIN_W-1:0] turn_gain_reg;
    logic [LIM_W-1:0]  max_speed_reg;
    hwm_ctl_t          sc_ctl;
    logic [NUM_W-1:0]  sc_num [3];
    logic [SUM_W-1:0]  sc_den;
    hwm_ctl_t          dv_ctl;
    logic [QUO_W-1:0]  dv_quo [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_gain_reg <= LINEAR_GAIN_RST;
            turn_gain_reg   <= TURN_GAIN_RST;
            max_speed_reg   <= MAX_SPEED_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_LINEAR_GAIN: linear_gain_reg <= cfg_data;
                REG_TURN_GAIN:   turn_gain_reg   <= cfg_data;
                REG_MAX_SPEED:   max_speed_reg   <= cfg_data[LIM_W-1:0];
                default:         ;
            endcase
        end
    end

    assign busy = 1'b0;

    hwm_scale #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW),
        .SUM_W     (SUM_W),
        .NUM_W     (NUM_W)
    ) u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (start && !busy),
        .forward_speed (forward_speed),
        .lateral_speed (lateral_speed),
        .turn_rate     (turn_rate),
        .linear_gain   (linear_gain_reg),
        .turn_gain     (turn_gain_reg),
        .max_speed     (max_speed_reg),
        .ctl           (sc_ctl),
        .num           (sc_num),
        .den           (sc_den)
    );

    hwm_div #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (sc_ctl),
        .num     (sc_num),
        .den     (sc_den),
        .ctl_out (dv_ctl),
        .quo     (dv_quo)
    );

    hwm_mix u_mix (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl_in             (dv_ctl),
        .quo                (dv_quo),
        .done               (done),
        .rear_left_target   (rear_left_target),
        .rear_right_target  (rear_right_target),
        .front_left_target  (front_left_target),
        .front_right_target (front_right_target),
        .speed_limited      (speed_limited)
    );

endmodule

>>> sv/hwm_checker.sv
// Port-level checks for the holonomic wheel mixer, bound to the top level.
// Depends on hwm_pkg and holonomic_wheel_mixer.
module hwm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             done,
    input logic signed [hwm_pkg::OUT_W-1:0] rear_left_target,
    input logic signed [hwm_pkg::OUT_W-1:0] rear_right_target,
    input logic signed [hwm_pkg::OUT_W-1:0] front_left_target,
    input logic signed [hwm_pkg::OUT_W-1:0] front_right_target
);
    import hwm_pkg::*;

    logic [OUT_W-1:0] diag_a;
    logic [OUT_W-1:0] diag_b;

    assign diag_a = OUT_W'(rear_left_target + front_right_target);
    assign diag_b = OUT_W'(front_left_target + rear_right_target);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_beat_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("command beat lost");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result beat without command");

    a_diag_sum: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (diag_a == diag_b))
        else $error("wheel mix inconsistent");

endmodule

bind holonomic_wheel_mixer hwm_checker u_hwm_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .done               (done),
    .rear_left_target   (rear_left_target),
    .rear_right_target  (rear_right_target),
    .front_left_target  (front_left_target),
    .front_right_target (front_right_target)
);
